>>> rtl/u2rtf_pkg.sv
// ----------------------------------------------------------------------------
// u2rtf_pkg
// Shared types, character codes and the decimal weight table of the UTF-8 to
// RTF unicode escape converter.
// ----------------------------------------------------------------------------
package u2rtf_pkg;

   // default depth of the job queue between front and back
   localparam int QUEUE_DEPTH_DEF = 4;

   // lead byte classes
   localparam logic [7:0] ASCII_LIMIT  = 8'h80;
   localparam logic [7:0] LEAD2_FIRST  = 8'hC0;
   localparam logic [7:0] LEAD3_FIRST  = 8'hE0;
   localparam logic [7:0] LEAD4_FIRST  = 8'hF0;
   localparam logic [7:0] LEAD_INVALID = 8'hF8;

   // characters of the escape
   localparam logic [7:0] CH_BSLASH = 8'h5C;
   localparam logic [7:0] CH_U      = 8'h75;
   localparam logic [7:0] CH_MINUS  = 8'h2D;
   localparam logic [7:0] CH_QMARK  = 8'h3F;
   localparam logic [7:0] CH_ZERO   = 8'h30;

   // highest decimal digit position (ten thousands)
   localparam logic [2:0] POS_TOP = 3'd4;

   // one queued job: a plain byte or a full escape
   typedef struct packed {
      logic        is_esc;  // 1: escape, 0: plain byte
      logic [7:0]  data;    // plain byte
      logic        neg;     // escape value is negative
      logic [15:0] mag;     // magnitude, 0..32768
      logic [2:0]  start;   // position of the leading digit
   } job_type;

   // weight of a decimal digit position
   function automatic logic [15:0] pow10(input logic [2:0] pos);
      logic [15:0] w;
      case (pos)
         3'd0:    w = 16'd1;
         3'd1:    w = 16'd10;
         3'd2:    w = 16'd100;
         3'd3:    w = 16'd1000;
         3'd4:    w = 16'd10000;
         default: w = 16'd1;
      endcase
      return w;
   endfunction

endpackage

>>> rtl/u2rtf_front.sv
// ----------------------------------------------------------------------------
// u2rtf_front
// Accepts UTF-8 bytes, tracks open sequences and pushes plain-byte and
// escape jobs into the queue.
// ----------------------------------------------------------------------------
module u2rtf_front
   import u2rtf_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_in_byte,
   input  logic        req_end_of_text,
   output logic        push,
   output job_type     push_job,
   input  logic        q_full
);

   logic [1:0]  remain_ff, remain_in;
   logic [15:0] acc_ff, acc_in;
   logic        accept;
   logic [15:0] code16;

   assign req_stall = q_full;
   assign accept    = req_valid && !q_full;
   assign code16    = {acc_ff[9:0], req_in_byte[5:0]};

   // decode one byte
   always_comb begin
      remain_in      = remain_ff;
      acc_in         = acc_ff;
      push           = 1'b0;
      push_job       = '0;
      push_job.neg   = code16[15];
      push_job.mag   = code16[15] ? 16'(~code16 + 16'd1) : code16;
      if (push_job.mag >= 16'd10000)     push_job.start = 3'd4;
      else if (push_job.mag >= 16'd1000) push_job.start = 3'd3;
      else if (push_job.mag >= 16'd100)  push_job.start = 3'd2;
      else if (push_job.mag >= 16'd10)   push_job.start = 3'd1;
      else                               push_job.start = 3'd0;
      push_job.data  = req_in_byte;

      if (remain_ff != 2'd0) begin
         // continuation, taken without checking
         acc_in    = code16;
         remain_in = remain_ff - 2'd1;
         if (remain_ff == 2'd1) begin
            push            = accept;
            push_job.is_esc = 1'b1;
            acc_in          = 16'd0;
         end
      end else if (req_in_byte < ASCII_LIMIT) begin
         push = accept && (req_in_byte != 8'd0);
      end else if (req_in_byte < LEAD2_FIRST) begin
         // stray continuation: dropped
      end else if (req_in_byte < LEAD3_FIRST) begin
         acc_in    = {11'd0, req_in_byte[4:0]};
         remain_in = 2'd1;
      end else if (req_in_byte < LEAD4_FIRST) begin
         acc_in    = {12'd0, req_in_byte[3:0]};
         remain_in = 2'd2;
      end else if (req_in_byte < LEAD_INVALID) begin
         acc_in    = {13'd0, req_in_byte[2:0]};
         remain_in = 2'd3;
      end

      // end of text drops any open sequence
      if (req_end_of_text) begin
         remain_in = 2'd0;
         acc_in    = 16'd0;
      end
   end

   // sequence state
   always_ff @(posedge clock) begin
      if (reset) begin
         remain_ff <= 2'd0;
         acc_ff    <= 16'd0;
      end else if (accept) begin
         remain_ff <= remain_in;
         acc_ff    <= acc_in;
      end
   end

endmodule

>>> rtl/u2rtf_fifo.sv
// ----------------------------------------------------------------------------
// u2rtf_fifo
// Short job queue between front and back.
// ----------------------------------------------------------------------------
module u2rtf_fifo
   import u2rtf_pkg::*;
#(
   parameter int DEPTH = QUEUE_DEPTH_DEF
)
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  job_type push_job,
   output logic    full,
   input  logic    pop,
   output job_type pop_job,
   output logic    empty
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   job_type            slot_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ff, wr_in, rd_ff, rd_in;
   logic [CNT_W-1:0]   count_ff, count_in;

   assign full    = (count_ff == CNT_W'(DEPTH));
   assign empty   = (count_ff == '0);
   assign pop_job = slot_ff[rd_ff];

   // pointer wrap and fill count
   always_comb begin
      wr_in    = (wr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ff + PTR_W'(1);
      rd_in    = (rd_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ff + PTR_W'(1);
      count_in = count_ff;
      if (push && !pop)      count_in = count_ff + CNT_W'(1);
      else if (!push && pop) count_in = count_ff - CNT_W'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         if (push) wr_ff <= wr_in;
         if (pop)  rd_ff <= rd_in;
         count_ff <= count_in;
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (push) slot_ff[wr_ff] <= push_job;
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> !full) else $error("queue push while full");
   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> !empty) else $error("queue pop while empty");
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH)) else $error("queue count out of range");

endmodule

>>> rtl/u2rtf_back.sv
// ----------------------------------------------------------------------------
// u2rtf_back
// Turns queued jobs into output characters, one a cycle while rsp_stall is
// low, digits most significant first, through an output register.
// ----------------------------------------------------------------------------
module u2rtf_back
   import u2rtf_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       q_empty,
   input  job_type    q_job,
   output logic       pop,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_out_last
);

   localparam logic [2:0] PH_IDLE  = 3'd0;
   localparam logic [2:0] PH_U     = 3'd1;
   localparam logic [2:0] PH_SIGN  = 3'd2;
   localparam logic [2:0] PH_DIGIT = 3'd3;
   localparam logic [2:0] PH_QMARK = 3'd4;

   logic [2:0]  phase_ff, phase_in;
   logic [15:0] rem_ff, rem_in;
   logic        neg_ff, neg_in;
   logic [2:0]  pos_ff, pos_in;
   logic        valid_ff, valid_in;
   logic [7:0]  byte_ff, byte_in;
   logic        last_ff, last_in;
   logic        adv;
   logic [15:0] weight;
   logic [19:0] thr;
   logic [3:0]  digit;
   logic [15:0] sub;

   assign adv          = !valid_ff || !rsp_stall;
   assign rsp_valid    = valid_ff;
   assign rsp_out_byte = byte_ff;
   assign rsp_out_last = last_ff;

   // digit at the current position: count of weight multiples that fit
   always_comb begin
      weight = pow10(pos_ff);
      digit  = 4'd0;
      sub    = 16'd0;
      thr    = 20'd0;
      for (int k = 1; k <= 9; k++) begin
         thr = 20'(k) * {4'd0, weight};
         if ({4'd0, rem_ff} >= thr) begin
            digit = 4'(k);
            sub   = thr[15:0];
         end
      end
   end

   // character sequencer
   always_comb begin
      phase_in = phase_ff;
      rem_in   = rem_ff;
      neg_in   = neg_ff;
      pos_in   = pos_ff;
      valid_in = 1'b0;
      byte_in  = 8'd0;
      last_in  = 1'b0;
      pop      = 1'b0;
      case (phase_ff)
         PH_IDLE: begin
            if (!q_empty) begin
               pop      = adv;
               valid_in = 1'b1;
               if (q_job.is_esc) begin
                  byte_in  = CH_BSLASH;
                  phase_in = PH_U;
                  rem_in   = q_job.mag;
                  neg_in   = q_job.neg;
                  pos_in   = q_job.start;
               end else begin
                  byte_in = q_job.data;
                  last_in = 1'b1;
               end
            end
         end
         PH_U: begin
            valid_in = 1'b1;
            byte_in  = CH_U;
            phase_in = neg_ff ? PH_SIGN : PH_DIGIT;
         end
         PH_SIGN: begin
            valid_in = 1'b1;
            byte_in  = CH_MINUS;
            phase_in = PH_DIGIT;
         end
         PH_DIGIT: begin
            valid_in = 1'b1;
            byte_in  = CH_ZERO + {4'd0, digit};
            rem_in   = rem_ff - sub;
            if (pos_ff == 3'd0) phase_in = PH_QMARK;
            else                pos_in   = pos_ff - 3'd1;
         end
         PH_QMARK: begin
            valid_in = 1'b1;
            byte_in  = CH_QMARK;
            last_in  = 1'b1;
            phase_in = PH_IDLE;
         end
         default: begin
            phase_in = PH_IDLE;
         end
      endcase
   end

   // control
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         valid_ff <= 1'b0;
      end else if (adv) begin
         phase_ff <= phase_in;
         valid_ff <= valid_in;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      if (adv) begin
         rem_ff  <= rem_in;
         neg_ff  <= neg_in;
         pos_ff  <= pos_in;
         byte_ff <= byte_in;
         last_ff <= last_in;
      end
   end

   a_rem_fits: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_DIGIT && pos_ff != POS_TOP)
         |-> rem_ff < 16'(16'd10 * pow10(pos_ff)))
      else $error("remainder too large for digit position");
   a_pos_range: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_DIGIT) |-> pos_ff <= POS_TOP)
      else $error("digit position out of range");
   a_last_ends_esc: assert property (@(posedge clock) disable iff (reset)
      (adv && phase_ff == PH_QMARK) |=> (phase_ff == PH_IDLE && last_ff))
      else $error("escape not closed with last");

endmodule

>>> rtl/utf8_to_rtf_unicode_escape.sv
// ----------------------------------------------------------------------------
// utf8_to_rtf_unicode_escape
// UTF-8 byte stream to RTF \uN? escapes; ASCII other than NUL passes through.
//
//   channel | ports                                      | dir
//   req     | req_valid req_stall req_in_byte req_end_of_text | in
//   rsp     | rsp_valid rsp_stall rsp_out_byte rsp_out_last   | out
//
// One input byte a cycle is taken while the job queue has room.
// Output is one character a cycle while rsp_stall is low: a plain byte is one
// character, an escape is \, u, a minus if negative, the digits and ?, set by
// the back sequencer, which emits the characters through its output register.
// Reset is synchronous and clears sequence state, queue and output valid.
// rsp_stall holds the output register; the queue then fills and req_stall rises.
// ----------------------------------------------------------------------------
module utf8_to_rtf_unicode_escape
   import u2rtf_pkg::*;
#(
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
)
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_in_byte,
   input  logic       req_end_of_text,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_out_last
);

   logic    push, pop, q_full, q_empty;
   job_type push_job, pop_job;

   // byte decode
   u2rtf_front u_front (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_in_byte     (req_in_byte),
      .req_end_of_text (req_end_of_text),
      .push            (push),
      .push_job        (push_job),
      .q_full          (q_full)
   );

   // job queue
   u2rtf_fifo #(
      .DEPTH (QUEUE_DEPTH)
   ) u_fifo (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_job (push_job),
      .full     (q_full),
      .pop      (pop),
      .pop_job  (pop_job),
      .empty    (q_empty)
   );

   // character output
   u2rtf_back u_back (
      .clock        (clock),
      .reset        (reset),
      .q_empty      (q_empty),
      .q_job        (pop_job),
      .pop          (pop),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_out_byte (rsp_out_byte),
      .rsp_out_last (rsp_out_last)
   );

endmodule
